### hdl/dcpc_pkg.sv
package dcpc_pkg;

    localparam int NUM_TELESCOPES_DEF = 8;
    localparam int NUM_STRIPS_DEF     = 32;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int ADC_BITS_DEF       = 16;

    localparam int TEL_W    = 3;
    localparam int STRIP_W  = 5;
    localparam int POS_W    = 6;
    localparam int CH_W     = 16;
    localparam int EN_W     = 48;
    localparam int CO_W     = 32;
    localparam int RES_W    = 48;
    localparam int ACC_W    = 84;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int S_DATA_W = 200;
    localparam int CFG_W    = 2;

    // interleaved strip mapping
    localparam int ILV_HALF = 16;
    localparam int ILV_STEP = 2;

    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // configuration register indexes
    localparam logic CFG_ORDER = 1'b0;
    localparam logic CFG_ILV   = 1'b1;

    typedef enum logic [1:0] {
        K_LOAD    = 2'd0,
        K_ENERGY  = 2'd1,
        K_TIME    = 2'd2,
        K_REVERSE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SAT        = 2'd1,
        ST_ZERO_SLOPE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_READ = 3'd1,
        S_MUL  = 3'd2,
        S_ACC  = 3'd3,
        S_DIV  = 3'd4,
        S_FIN  = 3'd5,
        S_DONE = 3'd6
    } t_state;

    typedef enum logic [2:0] {
        M_LIN  = 3'd0,
        M_SQR  = 3'd1,
        M_QUAD = 3'd2,
        M_CUBE = 3'd3,
        M_TLO  = 3'd4,
        M_THI  = 3'd5
    } t_step;

    typedef struct packed {
        logic [1:0] order;
        logic       ilv;
    } t_cfg;

    typedef struct packed {
        logic signed [CO_W-1:0] a3;
        logic signed [CO_W-1:0] a2;
        logic signed [CO_W-1:0] icpt;
        logic signed [CO_W-1:0] slope;
    } t_entry;

endpackage

### hdl/dcpc_ram.sv
module dcpc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/dcpc_front.sv
module dcpc_front #(
    parameter int NUM_TELESCOPES = 8,
    parameter int NUM_STRIPS     = 32,
    parameter int ADC_BITS       = 16,
    parameter int AW             = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dcpc_pkg::t_cfg                  i_cfg,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [1:0]                      i_s_tuser,
    input  logic [dcpc_pkg::S_DATA_W-1:0]   i_s_tdata,
    output logic                            o_q_valid,
    input  logic                            i_q_pop,
    output dcpc_pkg::t_kind                 o_q_kind,
    output logic                            o_q_oob,
    output logic [AW-1:0]                   o_q_addr,
    output logic [dcpc_pkg::CH_W-1:0]       o_q_ch,
    output logic [dcpc_pkg::EN_W-1:0]       o_q_energy,
    output dcpc_pkg::t_entry                o_q_entry
);
    import dcpc_pkg::*;

    localparam int CMD_W = 2 + 1 + AW + CH_W + EN_W + $bits(t_entry);
    localparam logic [CH_W-1:0] CH_MASK = CH_W'((33'd1 << ADC_BITS) - 33'd1);

    t_kind              kind;
    logic [TEL_W-1:0]   tel;
    logic [STRIP_W-1:0] strip;
    logic [POS_W-1:0]   pos;
    logic               oob;
    logic [AW-1:0]      addr;
    t_entry             entry;
    logic [CMD_W-1:0]   cmd;
    logic [CMD_W-1:0]   r_q [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    logic               push;

    always_comb begin
        kind  = t_kind'(i_s_tuser);
        tel   = i_s_tdata[2:0];
        strip = i_s_tdata[7:3];
        if (kind == K_LOAD && i_cfg.ilv) begin
            if (int'(strip) < ILV_HALF) begin
                pos = POS_W'(int'(strip) * ILV_STEP + 1);
            end else begin
                pos = POS_W'((int'(strip) - ILV_HALF) * ILV_STEP);
            end
        end else begin
            pos = POS_W'(strip);
        end
        oob  = (int'(tel) >= NUM_TELESCOPES) || (int'(pos) >= NUM_STRIPS);
        addr = AW'(int'(tel) * NUM_STRIPS + int'(pos));
        entry.slope = i_s_tdata[103:72];
        entry.icpt  = i_s_tdata[135:104];
        entry.a2    = (i_cfg.order >= 2'd2) ? i_s_tdata[167:136] : '0;
        entry.a3    = (i_cfg.order == 2'd3) ? i_s_tdata[199:168] : '0;
        cmd = {kind, oob, addr, i_s_tdata[23:8] & CH_MASK, i_s_tdata[71:24], entry};
    end

    assign o_s_tready = (r_cnt != 2'd2);
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    assign {o_q_kind, o_q_oob, o_q_addr, o_q_ch, o_q_energy, o_q_entry} = r_q[r_rp];
endmodule

### hdl/dcpc_back.sv
module dcpc_back #(
    parameter int NUM_TELESCOPES = 8,
    parameter int NUM_STRIPS     = 32,
    parameter int FRAC_BITS      = 16,
    parameter int AW             = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dcpc_pkg::t_cfg               i_cfg,
    input  logic                         i_q_valid,
    output logic                         o_q_pop,
    input  dcpc_pkg::t_kind              i_q_kind,
    input  logic                         i_q_oob,
    input  logic [AW-1:0]                i_q_addr,
    input  logic [dcpc_pkg::CH_W-1:0]    i_q_ch,
    input  logic [dcpc_pkg::EN_W-1:0]    i_q_energy,
    input  dcpc_pkg::t_entry             i_q_entry,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [dcpc_pkg::RES_W-1:0]   o_m_tdata,
    output logic [1:0]                   o_m_tuser
);
    import dcpc_pkg::*;

    localparam int NW    = EN_W + 1 + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    t_state r_state, n_state;
    t_step  r_step;
    t_kind  r_kind;
    logic   r_oob;
    logic [CH_W-1:0] r_ch;
    logic [EN_W-1:0] r_energy;
    t_entry r_ent;
    t_entry ent;
    logic [$bits(t_entry)-1:0] ram_rdata;
    logic ram_we;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  r_acc;
    logic [31:0] r_ch2;
    logic [63:0] r_t;

    logic [NW-1:0]    r_num, r_q;
    logic [32:0]      r_rem, rem_sh;
    logic [31:0]      r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             ge;
    logic signed [EN_W:0] diff;
    logic [EN_W:0]        mag;

    logic [RES_W-1:0] r_val;
    t_status          r_stat;
    logic             r_out_v;
    logic [RES_W-1:0] r_out_data;
    t_status          r_out_stat;
    logic             load_out;
    logic [ACC_W-RES_W:0] acc_hi;
    logic             acc_fits;
    logic             q_sat;

    dcpc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_TELESCOPES * NUM_STRIPS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_addr),
        .i_wdata (i_q_entry),
        .i_raddr (i_q_addr),
        .o_rdata (ram_rdata)
    );

    // entries outside the table read as zero coefficients
    assign ent      = r_oob ? '0 : t_entry'(ram_rdata);
    assign load_out = (r_state == S_DONE) && (!r_out_v || i_m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_kind != K_LOAD) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                unique case (r_kind)
                    K_ENERGY:  n_state = S_MUL;
                    K_TIME:    n_state = S_FIN;
                    K_REVERSE: n_state = (ent.slope == '0) ? S_DONE : S_DIV;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                unique case (r_step)
                    M_LIN:   n_state = (i_cfg.order == 2'd1) ? S_FIN : S_MUL;
                    M_QUAD:  n_state = (i_cfg.order == 2'd2) ? S_FIN : S_MUL;
                    M_THI:   n_state = S_FIN;
                    default: n_state = S_MUL;
                endcase
            end
            S_DIV:  n_state = (r_cnt == CNT_W'(1)) ? S_FIN : S_DIV;
            S_FIN:  n_state = S_DONE;
            S_DONE: n_state = load_out ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_state == S_IDLE) && i_q_valid;
        ram_we  = o_q_pop && (i_q_kind == K_LOAD) && !i_q_oob;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // shared multiplier operands
    always_comb begin
        case (r_step)
            M_LIN: begin
                mul_a = {r_ent.slope[CO_W-1], r_ent.slope};
                mul_b = MUL_W'(r_ch);
            end
            M_SQR: begin
                mul_a = MUL_W'(r_ch);
                mul_b = MUL_W'(r_ch);
            end
            M_QUAD: begin
                mul_a = {1'b0, r_ch2};
                mul_b = {r_ent.a2[CO_W-1], r_ent.a2};
            end
            M_CUBE: begin
                mul_a = {1'b0, r_ch2};
                mul_b = {r_ent.a3[CO_W-1], r_ent.a3};
            end
            M_TLO: begin
                mul_a = {1'b0, r_t[31:0]};
                mul_b = MUL_W'(r_ch);
            end
            default: begin
                mul_a = {r_t[63], r_t[63:32]};
                mul_b = MUL_W'(r_ch);
            end
        endcase
        prod_ext = ACC_W'(r_prod);
    end

    always_comb begin
        diff   = $signed({r_energy[EN_W-1], r_energy})
               - $signed((EN_W+1)'(ent.icpt));
        mag    = diff[EN_W] ? (EN_W+1)'(-diff) : (EN_W+1)'(diff);
        rem_sh = {r_rem[31:0], r_num[NW-1]};
        ge     = rem_sh >= {1'b0, r_div};
        acc_hi = r_acc[ACC_W-1:RES_W-1];
        acc_fits = (acc_hi == '0) || (acc_hi == '1);
        q_sat  = r_q > (NW'(RES_MAX) + NW'(r_neg));
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind   <= i_q_kind;
                r_oob    <= i_q_oob;
                r_ch     <= i_q_ch;
                r_energy <= i_q_energy;
            end
            S_READ: begin
                r_ent  <= ent;
                r_step <= M_LIN;
                // only a reverse item reports a zero slope
                r_stat <= (r_kind == K_REVERSE && ent.slope == '0) ? ST_ZERO_SLOPE : ST_OK;
                if (r_kind == K_TIME) begin
                    r_acc <= (ACC_W'(r_ch) <<< FRAC_BITS) + ACC_W'(ent.icpt);
                end else begin
                    r_acc <= ACC_W'(ent.icpt);
                end
                r_val  <= '0;
                r_neg <= diff[EN_W] ^ ent.slope[CO_W-1];
                r_num <= {mag, {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= CNT_W'(NW);
                r_div <= ent.slope[CO_W-1] ? 32'(-ent.slope) : 32'(ent.slope);
            end
            S_MUL: begin
                r_prod <= mul_a * mul_b;
            end
            S_ACC: begin
                case (r_step)
                    M_LIN: begin
                        r_acc  <= r_acc + prod_ext;
                        r_step <= M_SQR;
                    end
                    M_SQR: begin
                        r_ch2  <= r_prod[31:0];
                        r_step <= M_QUAD;
                    end
                    M_QUAD: begin
                        r_acc  <= r_acc + prod_ext;
                        r_step <= M_CUBE;
                    end
                    M_CUBE: begin
                        r_t    <= r_prod[63:0];
                        r_step <= M_TLO;
                    end
                    M_TLO: begin
                        r_acc  <= r_acc + prod_ext;
                        r_step <= M_THI;
                    end
                    default: begin
                        r_acc <= r_acc + (prod_ext <<< 32);
                    end
                endcase
            end
            S_DIV: begin
                r_rem <= ge ? rem_sh - {1'b0, r_div} : rem_sh;
                r_q   <= {r_q[NW-2:0], ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_FIN: begin
                if (r_kind == K_REVERSE) begin
                    if (q_sat) begin
                        r_val  <= r_neg ? RES_MIN : RES_MAX;
                        r_stat <= ST_SAT;
                    end else begin
                        r_val <= r_neg ? RES_W'(-r_q[RES_W-1:0]) : r_q[RES_W-1:0];
                    end
                end else if (acc_fits) begin
                    r_val <= r_acc[RES_W-1:0];
                end else begin
                    r_val  <= r_acc[ACC_W-1] ? RES_MIN : RES_MAX;
                    r_stat <= ST_SAT;
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_out_data <= r_val;
            r_out_stat <= r_stat;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_stat;
endmodule

### hdl/detector_channel_polynomial_calibration.sv
// Per-channel cubic energy calibration. Load items (tuser 0) write four Q16.16 coefficients
// for one telescope and strip and give no result; energy (1), time (2) and reverse (3) items
// each give one Q32.16 result with a status in tuser (ok, saturated, zero slope). A load
// is written to the table as the back end takes it. Energy runs on one shared 33x33
// multiplier, one product at a time. Reverse calibration is set by a one-bit-per-cycle
// restoring divider of 49+FRAC_BITS steps. A two-item queue in front keeps accepting
// while the back end works, until it holds two items, and an output register holds
// the finished result. Registers are to be written only while the block is idle; the
// block itself does not enforce it; query only loaded entries.
module detector_channel_polynomial_calibration
    import dcpc_pkg::*;
#(
    parameter int NUM_TELESCOPES = NUM_TELESCOPES_DEF,
    parameter int NUM_STRIPS     = NUM_STRIPS_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int ADC_BITS       = ADC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // action
    input  logic [1:0]           s_tuser,
    // telescope, strip, channel, energy_in, slope_in, intercept_in, quad_in, cubic_in
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_value
    output logic [RES_W-1:0]     m_tdata,
    // status
    output logic [1:0]           m_tuser
);
    localparam int AW = (NUM_TELESCOPES * NUM_STRIPS > 1) ?
                        $clog2(NUM_TELESCOPES * NUM_STRIPS) : 1;

    logic [1:0]      r_order;
    logic            r_ilv;
    t_cfg            cfg;
    logic            q_valid;
    logic            q_pop;
    t_kind           q_kind;
    logic            q_oob;
    logic [AW-1:0]   q_addr;
    logic [CH_W-1:0] q_ch;
    logic [EN_W-1:0] q_energy;
    t_entry          q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 2'd1;
            r_ilv   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ORDER: r_order <= i_cfg_wdata;
                default:   r_ilv   <= i_cfg_wdata[0];
            endcase
        end
    end

    // order zero behaves as order one
    assign cfg.order = (r_order == 2'd0) ? 2'd1 : r_order;
    assign cfg.ilv   = r_ilv;

    dcpc_front #(
        .NUM_TELESCOPES (NUM_TELESCOPES),
        .NUM_STRIPS     (NUM_STRIPS),
        .ADC_BITS       (ADC_BITS),
        .AW             (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tuser  (s_tuser),
        .i_s_tdata  (s_tdata),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_kind   (q_kind),
        .o_q_oob    (q_oob),
        .o_q_addr   (q_addr),
        .o_q_ch     (q_ch),
        .o_q_energy (q_energy),
        .o_q_entry  (q_entry)
    );

    dcpc_back #(
        .NUM_TELESCOPES (NUM_TELESCOPES),
        .NUM_STRIPS     (NUM_STRIPS),
        .FRAC_BITS      (FRAC_BITS),
        .AW             (AW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_kind   (q_kind),
        .i_q_oob    (q_oob),
        .i_q_addr   (q_addr),
        .i_q_ch     (q_ch),
        .i_q_energy (q_energy),
        .i_q_entry  (q_entry),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back end took an item from an empty queue");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == ST_SAT) |-> (m_tdata == RES_MAX || m_tdata == RES_MIN))
        else $error("saturated result is not a range limit");

    a_zero_slope_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == ST_ZERO_SLOPE) |-> (m_tdata == '0))
        else $error("zero slope result is not zero");
`endif
endmodule
